// ===== sv/positional_list_store_assert.svh =====
// Assertion macros shared by the positional list store RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PLST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plst assertion failed");
// next-cycle implication
`define PLST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plst assertion failed");
`else
`define PLST_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PLST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/plst_pkg.sv =====
// Types and codes shared by the positional list store controller and datapath.
// No dependencies.
`default_nettype none

package plst_pkg;

   // operation codes carried by a request beat
   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_AFTER = 3'd1,
      OP_INS_END   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_AT    = 3'd4,
      OP_DEL_END   = 3'd5,
      OP_SEARCH    = 3'd6,
      OP_DUMP      = 3'd7
   } op_type;

   // status codes of a response beat
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_SCAN = 2'd2
   } state_type;

   // what the output register is loaded with
   typedef enum logic [1:0] {
      OUT_STATUS = 2'd0,
      OUT_SRCH   = 2'd1,
      OUT_ELEM   = 2'd2
   } out_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load_req;
      logic        exec_upd;
      logic        scan_clr;
      logic        scan_step;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      op_type op;
      logic   list_empty;
      logic   scan_last;
      logic   out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/plst_dpath.sv =====
// Datapath of the positional list store: shifting cells, fill count, scan
// counter and the response register. Depends on plst_pkg and the assert header.
`default_nettype none
`include "positional_list_store_assert.svh"

module plst_dpath #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire plst_pkg::cmd_type  cmd,
   output plst_pkg::sts_type       sts,
   input  wire logic [2:0]         req_op,
   input  wire logic signed [31:0] req_value,
   input  wire logic [4:0]         req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic signed [31:0]      rsp_element,
   output logic [4:0]              rsp_length,
   output logic                    rsp_last
);
   import plst_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned PW = (CW > 5) ? CW : 5;

   // latched request
   op_type             op_ff;
   logic signed [31:0] value_ff;
   logic [4:0]         pos_ff;

   // list storage
   logic signed [31:0] cells_ff [DEPTH];
   logic signed [31:0] cells_in [DEPTH];
   logic signed [31:0] prev_w   [DEPTH];
   logic signed [31:0] next_w   [DEPTH];
   logic [CW-1:0]      fill_ff, fill_in;

   // scan state
   logic [IW-1:0] cnt_ff;
   logic          found_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic               rsp_found_ff;
   logic signed [31:0] rsp_element_ff;
   logic [4:0]         rsp_length_ff;
   logic               rsp_last_ff;

   logic [PW-1:0] pos_w, fill_w, fill_in_w;
   logic          full, empty, pos_bad, is_ins, upd_ok, do_upd, match, out_free, scan_last;
   status_type    status_w;
   logic [CW-1:0] idx;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // range checks
   assign pos_w   = PW'(pos_ff);
   assign fill_w  = PW'(fill_ff);
   assign full    = (fill_ff == CW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign pos_bad = (pos_ff == '0) || (pos_w > fill_w);
   assign is_ins  = (op_ff == OP_INS_FRONT) || (op_ff == OP_INS_AFTER) ||
                    (op_ff == OP_INS_END);

   // status and target index of an update
   always_comb begin
      status_w = ST_OK;
      idx      = '0;
      case (op_ff)
         OP_INS_FRONT: begin
            status_w = full ? ST_FULL : ST_OK;
         end
         OP_INS_AFTER: begin
            status_w = full ? ST_FULL : (pos_bad ? ST_RANGE : ST_OK);
            idx      = CW'(pos_w);
         end
         OP_INS_END: begin
            status_w = full ? ST_FULL : ST_OK;
            idx      = fill_ff;
         end
         OP_DEL_FRONT: begin
            status_w = empty ? ST_EMPTY : ST_OK;
         end
         OP_DEL_AT: begin
            status_w = empty ? ST_EMPTY : (pos_bad ? ST_RANGE : ST_OK);
            idx      = CW'(pos_w - PW'(1));
         end
         OP_DEL_END: begin
            status_w = empty ? ST_EMPTY : ST_OK;
            idx      = fill_ff - CW'(1);
         end
         OP_SEARCH: begin
            status_w = ST_OK;
         end
         OP_DUMP: begin
            status_w = empty ? ST_EMPTY : ST_OK;
         end
         default: begin
            status_w = ST_OK;
         end
      endcase
   end

   assign upd_ok = (status_w == ST_OK) && (op_ff != OP_SEARCH) && (op_ff != OP_DUMP);
   assign do_upd = cmd.exec_upd && upd_ok;

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (do_upd) begin
         fill_in = is_ins ? (fill_ff + CW'(1)) : (fill_ff - CW'(1));
      end
   end
   assign fill_in_w = PW'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // neighbor taps of each cell
   for (genvar g = 0; g < DEPTH; g++) begin : g_tap
      if (g == 0) begin : g_first
         assign prev_w[g] = '0;
      end else begin : g_mid
         assign prev_w[g] = cells_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_lastc
         assign next_w[g] = '0;
      end else begin : g_body
         assign next_w[g] = cells_ff[g+1];
      end
   end

   // per-cell shift: insert opens a gap, delete closes one, scan rotates the list
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_upd && is_ins) begin
            if (CW'(i) == idx) begin
               cells_in[i] = value_ff;
            end else if ((CW'(i) > idx) && (CW'(i) <= fill_ff)) begin
               cells_in[i] = prev_w[i];
            end
         end else if (do_upd) begin
            if ((CW'(i) >= idx) && (CW'(i + 1) < fill_ff)) begin
               cells_in[i] = next_w[i];
            end
         end else if (cmd.scan_step) begin
            if (CW'(i + 1) < fill_ff) begin
               cells_in[i] = next_w[i];
            end else if (CW'(i + 1) == fill_ff) begin
               cells_in[i] = cells_ff[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   // scan counter and sticky match
   assign match     = (cells_ff[0] == value_ff);
   assign scan_last = (CW'(cnt_ff) == (fill_ff - CW'(1)));

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         cnt_ff   <= cnt_ff + IW'(1);
         found_ff <= found_ff | match;
      end
   end

   // response register
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_stall & rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_length_ff <= fill_in_w[4:0];
         case (cmd.out_sel)
            OUT_STATUS: begin
               rsp_status_ff  <= status_w;
               rsp_found_ff   <= 1'b0;
               rsp_element_ff <= '0;
               rsp_last_ff    <= 1'b1;
            end
            OUT_SRCH: begin
               rsp_status_ff  <= ST_OK;
               rsp_found_ff   <= found_ff | match;
               rsp_element_ff <= '0;
               rsp_last_ff    <= 1'b1;
            end
            OUT_ELEM: begin
               rsp_status_ff  <= ST_OK;
               rsp_found_ff   <= 1'b0;
               rsp_element_ff <= cells_ff[0];
               rsp_last_ff    <= scan_last;
            end
            default: begin
               rsp_status_ff  <= status_w;
               rsp_found_ff   <= 1'b0;
               rsp_element_ff <= '0;
               rsp_last_ff    <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_length  = rsp_length_ff;
   assign rsp_last    = rsp_last_ff;

   // status back to the controller
   assign sts.op         = op_ff;
   assign sts.list_empty = empty;
   assign sts.scan_last  = scan_last;
   assign sts.out_free   = out_free;

   // checks
   `PLST_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(DEPTH))
   `PLST_ASSERT_NOW(a_load_free, clock, reset, cmd.out_load, out_free)
   `PLST_ASSERT_NEXT(a_ins_grows, clock, reset, do_upd && is_ins,
      fill_ff == $past(fill_ff) + CW'(1))

endmodule

`default_nettype wire

// ===== sv/plst_ctrl.sv =====
// Controller state machine of the positional list store: request intake,
// update and scan sequencing. Depends on plst_pkg and the assert header.
`default_nettype none
`include "positional_list_store_assert.svh"

module plst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire plst_pkg::sts_type sts,
   output plst_pkg::cmd_type      cmd
);
   import plst_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               if ((sts.op == OP_SEARCH) || (sts.op == OP_DUMP)) begin
                  if (sts.list_empty) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_STATUS;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_SCAN;
                  end
               end else begin
                  cmd.exec_upd = 1'b1;
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = OUT_STATUS;
                  state_in     = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            if (sts.op == OP_SEARCH) begin
               // compare one cell per beat; report on the final one
               if (!sts.scan_last) begin
                  cmd.scan_step = 1'b1;
               end else if (sts.out_free) begin
                  cmd.scan_step = 1'b1;
                  cmd.out_load  = 1'b1;
                  cmd.out_sel   = OUT_SRCH;
                  state_in      = S_IDLE;
               end
            end else if (sts.out_free) begin
               // dump: one element per response beat
               cmd.scan_step = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.out_sel   = OUT_ELEM;
               if (sts.scan_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // checks
   `PLST_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall,
      state_ff == S_EXEC)
   `PLST_ASSERT_NOW(a_scan_nonempty, clock, reset, state_ff == S_SCAN, !sts.list_empty)
   `PLST_ASSERT_NOW(a_upd_only_exec, clock, reset, cmd.exec_upd || cmd.scan_clr,
      state_ff == S_EXEC)

endmodule

`default_nettype wire

// ===== sv/positional_list_store.sv =====
// Positional list store: an ordered list of up to DEPTH signed 32-bit values held in
// shifting cells, front in cell 0. Insert, delete and search requests give one response
// beat each; a dump gives one beat per element with rsp_last on the final one, or a
// single empty-status beat. Inserts and deletes go through intake, then an update in
// which every cell shifts at once, held until the response register is free. A search
// or a dump of a non-empty list rotates it through cell 0 one element a cycle (a dump
// pauses on a stalled response); that single compare/output point sets the scan time.
// The cells need no clearing after reset. Depends on plst_pkg, plst_ctrl and plst_dpath.
`default_nettype none

module positional_list_store #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic signed [31:0] req_value,
   input  wire logic [4:0]         req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic signed [31:0]      rsp_element,
   output logic [4:0]              rsp_length,
   output logic                    rsp_last
);
   import plst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   plst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and response register
   plst_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_element  (rsp_element),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ===== bench/tb_positional_list_store.sv =====
// Self-checking bench for positional_list_store: directed corner beats, then three
// random phases with changing back-pressure, checked against a shadow list.
// Depends on plst_pkg and the positional_list_store RTL.

module tb_positional_list_store;
   timeunit 1ns;
   timeprecision 1ps;

   import plst_pkg::*;

   localparam int unsigned LIST_DEPTH = 16;

   // Shadow of the list contents plus the response beats still owed by the block
   class list_shadow_type;
      typedef struct {
         logic [1:0]         status;
         logic               found;
         logic signed [31:0] element;
         logic [4:0]         length;
         logic               last;
      } beat_type;

      int                 capacity;
      logic signed [31:0] cells[$];
      beat_type           due_beats[$];

      function new(int depth);
         capacity = depth;
      endfunction

      function int fill_level();
         return cells.size();
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      function logic signed [31:0] pick_element();
         if (cells.size() == 0) return $urandom;
         return cells[$urandom_range(cells.size() - 1)];
      endfunction

      // Apply one accepted request and queue the beats it must produce
      function void apply_request(op_type op, logic signed [31:0] value, logic [4:0] position);
         beat_type   b;
         logic [1:0] st;
         int         n;
         st        = ST_OK;
         b.found   = 1'b0;
         b.element = '0;
         b.last    = 1'b1;
         n         = cells.size();
         case (op)
            OP_INS_FRONT: begin
               if (n >= capacity) st = ST_FULL;
               else cells.push_front(value);
            end
            OP_INS_AFTER: begin
               if (n >= capacity) st = ST_FULL;
               else if (position == 0 || position > n) st = ST_RANGE;
               else cells.insert(int'(position), value);
            end
            OP_INS_END: begin
               if (n >= capacity) st = ST_FULL;
               else cells.push_back(value);
            end
            OP_DEL_FRONT: begin
               if (n == 0) st = ST_EMPTY;
               else void'(cells.pop_front());
            end
            OP_DEL_AT: begin
               if (n == 0) st = ST_EMPTY;
               else if (position == 0 || position > n) st = ST_RANGE;
               else cells.delete(int'(position) - 1);
            end
            OP_DEL_END: begin
               if (n == 0) st = ST_EMPTY;
               else void'(cells.pop_back());
            end
            OP_SEARCH: begin
               foreach (cells[i]) if (cells[i] == value) b.found = 1'b1;
            end
            default: begin
               // dump: one beat per element, or a single empty beat
               if (n == 0) begin
                  st = ST_EMPTY;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     b.status  = ST_OK;
                     b.element = cells[i];
                     b.length  = 5'(n);
                     b.last    = (i == n - 1);
                     due_beats.push_back(b);
                  end
                  return;
               end
            end
         endcase
         b.status = st;
         b.length = 5'(cells.size());
         due_beats.push_back(b);
      endfunction

      // Compare one response beat with the oldest owed beat; empty string when it matches
      function string match_response(logic [1:0] st, logic fnd, logic signed [31:0] elem,
                                     logic [4:0] len, logic lst);
         beat_type want;
         if (due_beats.size() == 0)
            return $sformatf("unexpected beat st=%0d found=%0b elem=%0d len=%0d last=%0b",
                             st, fnd, elem, len, lst);
         want = due_beats.pop_front();
         if (st !== want.status || fnd !== want.found || elem !== want.element ||
             len !== want.length || lst !== want.last)
            return $sformatf({"got st=%0d found=%0b elem=%0d len=%0d last=%0b, ",
                              "want st=%0d found=%0b elem=%0d len=%0d last=%0b"},
                             st, fnd, elem, len, lst, want.status, want.found,
                             want.element, want.length, want.last);
         return "";
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic [2:0]         req_op = '0;
   logic signed [31:0] req_value = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_stall = 1'b0;
   wire                req_stall;
   wire                rsp_valid;
   wire  [1:0]         rsp_status;
   wire                rsp_found;
   wire  signed [31:0] rsp_element;
   wire  [4:0]         rsp_length;
   wire                rsp_last;

   list_shadow_type board = new(LIST_DEPTH);
   int              mismatches = 0;
   int              req_idle_pct = 0;
   int              rsp_idle_pct = 0;
   int              rsp_hold_cycles = 0;
   bit              growing = 1'b1;

   positional_list_store #(.DEPTH(LIST_DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_element  (rsp_element),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin : watch
      string msg;
      if (!reset) begin
         if (req_valid && !req_stall)
            board.apply_request(op_type'(req_op), req_value, req_position);
         if (rsp_valid && !rsp_stall) begin
            msg = board.match_response(rsp_status, rsp_found, rsp_element, rsp_length,
                                       rsp_last);
            if (msg != "") report_mismatch(msg);
         end
      end
   end

   // Receiver: random stall, or a long hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Offer one request beat, with random gaps first; returns at the next falling edge
   task automatic send_req(input op_type op, input logic signed [31:0] value,
                           input logic [4:0] position);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid    <= 1'b0;
         req_op       <= 3'($urandom);
         req_value    <= $urandom;
         req_position <= 5'($urandom);
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // Random request: the list walks between empty and full, with noise mixed in
   task automatic send_random_req();
      op_type             op;
      logic signed [31:0] v;
      logic [4:0]         p;
      int                 n;
      int                 r;
      n = board.fill_level();
      if (n >= LIST_DEPTH) growing = 1'b0;
      else if (n == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 8) op = OP_DUMP;
      else if (r < 20) op = OP_SEARCH;
      else if (r < (growing ? 76 : 44)) op = op_type'($urandom_range(2, 0));
      else op = op_type'($urandom_range(5, 3));

      r = $urandom_range(9);
      if (r < 7) p = 5'($urandom_range((n > 0) ? n : 1, 1));
      else if (r == 7) p = '0;
      else if (r == 8) p = 5'(n + 1);
      else p = 5'($urandom);

      r = $urandom_range(9);
      if (r < 3) begin
         case ($urandom_range(5))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = 0;
            3:       v = -1;
            4:       v = 1;
            default: v = 42;
         endcase
      end else if (r < 5 || (op == OP_SEARCH && r < 8)) begin
         v = board.pick_element();
      end else begin
         v = $urandom;
      end
      send_req(op, v, p);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      req_idle_pct = 10;
      rsp_idle_pct = 20;

      // Directed: empty list, range checks, value extremes, search hit and miss
      send_req(OP_DUMP,      0, 0);
      send_req(OP_DEL_FRONT, 0, 0);
      send_req(OP_DEL_AT,    0, 1);
      send_req(OP_DEL_END,   0, 0);
      send_req(OP_SEARCH,    0, 0);
      send_req(OP_INS_AFTER, 5, 1);
      send_req(OP_INS_FRONT, 32'sh8000_0000, 0);
      send_req(OP_INS_END,   32'sh7fff_ffff, 0);
      send_req(OP_INS_AFTER, 9, 0);
      send_req(OP_INS_AFTER, 9, 3);
      send_req(OP_INS_AFTER, 0, 2);
      send_req(OP_INS_AFTER, -1, 1);
      send_req(OP_SEARCH,    32'sh7fff_ffff, 0);
      send_req(OP_SEARCH,    12345, 0);
      send_req(OP_SEARCH,    32'sh8000_0000, 31);
      send_req(OP_DUMP,      0, 0);
      send_req(OP_DEL_AT,    0, 0);
      send_req(OP_DEL_AT,    0, 31);
      send_req(OP_DEL_AT,    0, 5);
      send_req(OP_DEL_AT,    0, 2);
      send_req(OP_DEL_FRONT, 0, 0);
      send_req(OP_DEL_END,   0, 0);
      send_req(OP_DUMP,      0, 0);
      send_req(OP_INS_FRONT, 32'sh5555_aaaa, 31);

      // Random phases: slow receiver, then slow sender, then full rate with a hold-off
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin req_idle_pct = 28; rsp_idle_pct = 79; end
            1:       begin req_idle_pct = 79; rsp_idle_pct = 28; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  rsp_hold_cycles = 300; end
         endcase
         repeat (115) send_random_req();
      end
      req_valid <= 1'b0;

      // Drain, then leave room for any stray beat
      while (board.pending() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
